// ===== rtl/vap_pkg.sv =====
// Package for the video memory access port.
// Holds sizes, request and register codes, shared structs and address helpers.
// No dependencies.
`default_nettype none
package vap_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int MEM_WORDS = MEM_BYTES / 2;
	localparam int WIDX_W    = $clog2(MEM_WORDS);

	localparam logic [2:0] REQ_ADDR_LO = 3'd0;
	localparam logic [2:0] REQ_ADDR_HI = 3'd1;
	localparam logic [2:0] REQ_WR_LO   = 3'd2;
	localparam logic [2:0] REQ_WR_HI   = 3'd3;
	localparam logic [2:0] REQ_RD_LO   = 3'd4;
	localparam logic [2:0] REQ_RD_HI   = 3'd5;

	localparam logic [2:0] REG_DISPLAY_OFF = 3'd0;
	localparam logic [2:0] REG_TALL_SCREEN = 3'd1;
	localparam logic [2:0] REG_INTERLACED  = 3'd2;
	localparam logic [2:0] REG_LINES       = 3'd3;
	localparam logic [2:0] REG_STEP_HIGH   = 3'd4;
	localparam logic [2:0] REG_REMAP       = 3'd5;
	localparam logic [2:0] REG_STEP_CODE   = 3'd6;

	localparam logic [8:0]  LINES_RESET  = 9'd262;
	localparam logic [10:0] CYC_LAST     = 11'd1362;
	localparam logic [10:0] CYC_WIN      = 11'd4;
	localparam logic [10:0] CYC_OPEN_BUS = 11'd6;
	localparam logic [8:0]  VIS_TALL     = 9'd239;
	localparam logic [8:0]  VIS_NORM     = 9'd224;
	localparam logic [8:0]  BLANK_TALL   = 9'd240;
	localparam logic [8:0]  BLANK_NORM   = 9'd225;

	localparam logic [1:0] REMAP_NONE = 2'd0;
	localparam logic [1:0] REMAP_5    = 2'd1;
	localparam logic [1:0] REMAP_6    = 2'd2;
	localparam logic [1:0] REMAP_7    = 2'd3;

	localparam logic [1:0] STEP_1  = 2'd0;
	localparam logic [1:0] STEP_32 = 2'd1;

	typedef struct packed {
		logic       display_off;
		logic       tall_screen;
		logic       interlaced;
		logic [8:0] lines_per_frame;
		logic       step_on_high;
		logic [1:0] remap_mode;
		logic [1:0] step_code;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic load;
		logic move;
	} vap_cmd_t;

	typedef struct packed {
		logic clear_last;
	} vap_stat_t;

	function automatic logic [15:0] remap_addr(input logic [15:0] a, input logic [1:0] mode);
		logic [15:0] r;
		unique case (mode)
			REMAP_NONE: r = a;
			REMAP_5:    r = {a[15:8], a[4:0], a[7:5]};
			REMAP_6:    r = {a[15:9], a[5:0], a[8:6]};
			REMAP_7:    r = {a[15:10], a[6:0], a[9:7]};
			default:    r = a;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] step_size(input logic [1:0] code);
		logic [15:0] s;
		unique case (code)
			STEP_1:  s = 16'd1;
			STEP_32: s = 16'd32;
			default: s = 16'd128;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/vram_access_port.sv =====
// Video memory access port: byte-addressed video memory reached through a
// 16-bit word address with bit remapping, and a 16-bit read-ahead buffer.
// Each item is one bus access (address byte write, data byte write or data
// byte read) and gives one result item. The memory is read at acceptance and
// the buffer is loaded in the next cycle; no new item is taken while the
// buffer loads or while the pending result slot is full. A finished result
// waits in an output register while the next item is accepted. After reset the
// memory is cleared one 16-bit word per cycle, during which no item is
// accepted; configuration writes are taken at any time.
// Depends on vap_pkg, vap_regs, vap_ctrl and vap_dp.
`default_nettype none
module vram_access_port import vap_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// wdata[7:0], beam_line[16:8], beam_cycle[27:17], odd_field[28],
	// open_bus[36:29], zero[39:37]
	input  wire logic [39:0] s_tdata,
	// req_type[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// rdata[7:0]
	output logic      [7:0]  m_tdata,
	// write_done[0]
	output logic             m_tuser
);

	cfg_t      cfg;
	vap_cmd_t  cmd;
	vap_stat_t stat;

	vap_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vap_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (s_tuser),
		.wdata      (s_tdata[7:0]),
		.beam_line  (s_tdata[16:8]),
		.beam_cycle (s_tdata[27:17]),
		.odd_field  (s_tdata[28]),
		.open_bus   (s_tdata[36:29]),
		.out_rdata  (m_tdata),
		.out_done   (m_tuser)
	);

endmodule
`default_nettype wire

// ===== rtl/vap_regs.sv =====
// Configuration registers of the video memory access port, APB-style port.
// Depends on vap_pkg.
`default_nettype none
module vap_regs import vap_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_off     <= 1'b0;
			cfg_q.tall_screen     <= 1'b0;
			cfg_q.interlaced      <= 1'b0;
			cfg_q.lines_per_frame <= LINES_RESET;
			cfg_q.step_on_high    <= 1'b0;
			cfg_q.remap_mode      <= 2'd0;
			cfg_q.step_code       <= 2'd0;
		end else if (wr_en) begin
			unique case (idx)
				REG_DISPLAY_OFF: cfg_q.display_off     <= pwdata[0];
				REG_TALL_SCREEN: cfg_q.tall_screen     <= pwdata[0];
				REG_INTERLACED:  cfg_q.interlaced      <= pwdata[0];
				REG_LINES:       cfg_q.lines_per_frame <= pwdata[8:0];
				REG_STEP_HIGH:   cfg_q.step_on_high    <= pwdata[0];
				REG_REMAP:       cfg_q.remap_mode      <= pwdata[1:0];
				REG_STEP_CODE:   cfg_q.step_code       <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (idx)
			REG_DISPLAY_OFF: prdata = {31'd0, cfg_q.display_off};
			REG_TALL_SCREEN: prdata = {31'd0, cfg_q.tall_screen};
			REG_INTERLACED:  prdata = {31'd0, cfg_q.interlaced};
			REG_LINES:       prdata = {23'd0, cfg_q.lines_per_frame};
			REG_STEP_HIGH:   prdata = {31'd0, cfg_q.step_on_high};
			REG_REMAP:       prdata = {30'd0, cfg_q.remap_mode};
			REG_STEP_CODE:   prdata = {30'd0, cfg_q.step_code};
			default:         prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/vap_ctrl.sv =====
// Controller of the video memory access port: memory clear, item sequencing
// and the valid flags of the pending and output result slots. Depends on vap_pkg.
`default_nettype none
module vap_ctrl import vap_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire vap_stat_t stat,
	output vap_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   pend_q;
	logic   out_q;
	logic   accept;
	logic   move;

	assign s_tready = (state_q == ST_IDLE) && !pend_q;
	assign accept   = s_tvalid && s_tready;
	assign move     = pend_q && (!out_q || m_tready);
	assign m_tvalid = out_q;

	assign cmd.clear  = (state_q == ST_CLEAR);
	assign cmd.accept = accept;
	assign cmd.load   = (state_q == ST_LOAD);
	assign cmd.move   = move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pend_q  <= 1'b0;
			out_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: if (stat.clear_last) state_q <= ST_IDLE;
				ST_IDLE:  if (accept) state_q <= ST_LOAD;
				ST_LOAD:  state_q <= ST_IDLE;
				default:  state_q <= ST_CLEAR;
			endcase
			if (accept) begin
				pend_q <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
			if (move) begin
				out_q <= 1'b1;
			end else if (m_tready) begin
				out_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/vap_dp.sv =====
// Datapath of the video memory access port: word address, read-ahead buffer,
// video memory with clear sweep, access windows and result slots. Depends on vap_pkg.
`default_nettype none
module vap_dp import vap_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire vap_cmd_t    cmd,
	output vap_stat_t        stat,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  wdata,
	input  wire logic [8:0]  beam_line,
	input  wire logic [10:0] beam_cycle,
	input  wire logic        odd_field,
	input  wire logic [7:0]  open_bus,
	output logic      [7:0]  out_rdata,
	output logic             out_done
);

	logic [15:0] video_mem [MEM_WORDS];

	logic [15:0] word_addr_q;
	logic [15:0] read_ahead_q;
	logic [WIDX_W-1:0] clr_cnt_q;
	logic [15:0] rd_s1;
	logic        pre_s1;
	logic        ok_s1;
	logic [7:0]  res_rdata_q;
	logic        res_done_q;
	logic [7:0]  out_rdata_q;
	logic        out_done_q;

	logic        is_addr, is_wr, is_rd;
	logic [15:0] wa_new, wa_pre, rd_map, wr_map;
	logic [WIDX_W-1:0] rd_idx, wr_idx;
	logic [9:0]  last_line;
	logic [8:0]  vis_line, blank_line;
	logic        read_ok, write_ok, step_hit, preload;
	logic [7:0]  wval, rdata_c;

	assign is_addr = (req_type == REQ_ADDR_LO) || (req_type == REQ_ADDR_HI);
	assign is_wr   = (req_type == REQ_WR_LO) || (req_type == REQ_WR_HI);
	assign is_rd   = (req_type == REQ_RD_LO) || (req_type == REQ_RD_HI);

	assign wa_new = (req_type == REQ_ADDR_LO) ? {word_addr_q[15:8], wdata}
	                                          : {wdata, word_addr_q[7:0]};
	assign wa_pre = is_addr ? wa_new : word_addr_q;
	assign rd_map = remap_addr(wa_pre, cfg.remap_mode);
	assign wr_map = remap_addr(word_addr_q, cfg.remap_mode);
	assign rd_idx = rd_map[WIDX_W-1:0];
	assign wr_idx = wr_map[WIDX_W-1:0];

	assign last_line = {1'b0, cfg.lines_per_frame}
	                 - {9'd0, ~(cfg.interlaced & ~odd_field)};
	assign vis_line   = cfg.tall_screen ? VIS_TALL : VIS_NORM;
	assign blank_line = cfg.tall_screen ? BLANK_TALL : BLANK_NORM;

	always_comb begin
		priority if (cfg.display_off) begin
			read_ok = 1'b1;
		end else if (({1'b0, beam_line} == last_line) && (beam_cycle == CYC_LAST)) begin
			read_ok = 1'b0;
		end else if (beam_line < vis_line) begin
			read_ok = 1'b0;
		end else if (beam_line == vis_line) begin
			read_ok = (beam_cycle == CYC_LAST);
		end else begin
			read_ok = 1'b1;
		end
	end

	always_comb begin
		wval = wdata;
		priority if (cfg.display_off) begin
			write_ok = 1'b1;
		end else if (beam_line == 9'd0) begin
			write_ok = (beam_cycle <= CYC_WIN) || (beam_cycle == CYC_OPEN_BUS);
			if (beam_cycle == CYC_OPEN_BUS) wval = open_bus;
		end else if (beam_line < blank_line) begin
			write_ok = 1'b0;
		end else if (beam_line == blank_line) begin
			write_ok = (beam_cycle > CYC_WIN);
		end else begin
			write_ok = 1'b1;
		end
	end

	always_comb begin
		priority if (is_wr) begin
			step_hit = ((req_type == REQ_WR_HI) == cfg.step_on_high);
		end else if (is_rd) begin
			step_hit = ((req_type == REQ_RD_HI) == cfg.step_on_high);
		end else begin
			step_hit = 1'b0;
		end
	end

	assign preload = is_addr || (is_rd && step_hit);

	always_comb begin
		unique case (req_type)
			REQ_RD_LO: rdata_c = read_ahead_q[7:0];
			REQ_RD_HI: rdata_c = read_ahead_q[15:8];
			default:   rdata_c = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			video_mem[clr_cnt_q] <= 16'd0;
		end else if (cmd.accept && is_wr && write_ok) begin
			if (req_type == REQ_WR_HI) begin
				video_mem[wr_idx][15:8] <= wval;
			end else begin
				video_mem[wr_idx][7:0] <= wval;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_s1       <= video_mem[rd_idx];
			pre_s1      <= preload;
			ok_s1       <= read_ok;
			res_rdata_q <= rdata_c;
			res_done_q  <= is_wr & write_ok;
		end
		if (cmd.move) begin
			out_rdata_q <= res_rdata_q;
			out_done_q  <= res_done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			word_addr_q  <= 16'd0;
			read_ahead_q <= 16'd0;
		end else begin
			if (cmd.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.accept) begin
				if (is_addr) begin
					word_addr_q <= wa_new;
				end else if (step_hit) begin
					word_addr_q <= word_addr_q + step_size(cfg.step_code);
				end
			end
			if (cmd.load && pre_s1) read_ahead_q <= ok_s1 ? rd_s1 : 16'd0;
		end
	end

	assign stat.clear_last = &clr_cnt_q;
	assign out_rdata       = out_rdata_q;
	assign out_done        = out_done_q;

endmodule
`default_nettype wire

// ===== rtl/vap_checker.sv =====
// Port-level checks for the video memory access port, bound to the top level.
// Depends on vram_access_port.
`default_nettype none
module vap_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tuser
);

	// an item blocks the port while the buffer loads
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted in back-to-back cycles");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result item changed");

	// a stored write never returns read data
	a_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'd0)
		else $error("write item returned nonzero data");

	// no item is taken in the cycle right after reset releases
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !s_tready)
		else $error("item accepted during memory clear");

endmodule

bind vram_access_port vap_checker u_vap_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
